// ----- src/assert_macros.svh -----
// assertion helpers used by the letter entry unit rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked on every rising clock edge out of reset
`define CHK_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication
`define CHK_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ----- src/mtnle_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mtnle_pkg
// Types, key codes and letter tables of the multi-tap numpad letter entry unit.
// ----------------------------------------------------------------------------
package mtnle_pkg;

   localparam int CODE_W = 8;
   localparam int IDX_W  = 2;

   localparam logic [CODE_W-1:0] KEY_FIRST  = 8'd71;
   localparam logic [CODE_W-1:0] KEY_LAST   = 8'd82;
   localparam logic [CODE_W-1:0] KEY_GAP    = 8'd74;
   localparam logic [CODE_W-1:0] KEY_LAYOUT = 8'd78;
   localparam logic [CODE_W-1:0] KEY_EMIT   = 8'd82;
   // latin groups on these keys hold four letters
   localparam logic [CODE_W-1:0] KEY_LONG_A = 8'd71;
   localparam logic [CODE_W-1:0] KEY_LONG_B = 8'd73;

   localparam logic [CODE_W-1:0] LAT_TAB [8][4] = '{
      '{8'h1E, 8'h30, 8'h2E, 8'h00},
      '{8'h20, 8'h12, 8'h21, 8'h00},
      '{8'h22, 8'h23, 8'h17, 8'h00},
      '{8'h24, 8'h25, 8'h26, 8'h00},
      '{8'h32, 8'h31, 8'h18, 8'h00},
      '{8'h19, 8'h10, 8'h13, 8'h1F},
      '{8'h14, 8'h16, 8'h2F, 8'h00},
      '{8'h11, 8'h2D, 8'h15, 8'h2C}
   };

   localparam logic [CODE_W-1:0] CYR_TAB [8][4] = '{
      '{8'h21, 8'h33, 8'h20, 8'h16},
      '{8'h26, 8'h14, 8'h27, 8'h19},
      '{8'h30, 8'h10, 8'h13, 8'h25},
      '{8'h2F, 8'h15, 8'h24, 8'h22},
      '{8'h23, 8'h2E, 8'h31, 8'h12},
      '{8'h1E, 8'h1A, 8'h11, 8'h2D},
      '{8'h17, 8'h18, 8'h1B, 8'h1F},
      '{8'h32, 8'h28, 8'h34, 8'h2C}
   };

   typedef struct packed {
      logic              composing;
      logic              latin;
      logic [IDX_W-1:0]  idx;
      logic [CODE_W-1:0] group_key;
   } state_type;

   typedef struct packed {
      logic       hit;
      logic [2:0] grp;
   } group_type;

   function automatic group_type group_of(input logic [CODE_W-1:0] key);
      group_type g;
      g.hit = 1'b1;
      unique case (key)
         8'd80:   g.grp = 3'd0;
         8'd81:   g.grp = 3'd1;
         8'd75:   g.grp = 3'd2;
         8'd76:   g.grp = 3'd3;
         8'd77:   g.grp = 3'd4;
         8'd71:   g.grp = 3'd5;
         8'd72:   g.grp = 3'd6;
         8'd73:   g.grp = 3'd7;
         default: begin
            g.hit = 1'b0;
            g.grp = 3'd0;
         end
      endcase
      return g;
   endfunction

   function automatic logic [CODE_W-1:0] letter_of(input logic [CODE_W-1:0] key,
                                                   input logic [IDX_W-1:0]  idx,
                                                   input logic              latin);
      group_type         g;
      logic              long_grp;
      logic [CODE_W-1:0] letter;
      g        = group_of(key);
      long_grp = (g.grp == 3'd5) || (g.grp == 3'd7);
      if (!g.hit) begin
         letter = '0;
      end else if (latin) begin
         // short latin groups have no fourth letter
         letter = (idx == 2'd3 && !long_grp) ? '0 : LAT_TAB[g.grp][idx];
      end else begin
         letter = CYR_TAB[g.grp][idx];
      end
      return letter;
   endfunction

endpackage
`default_nettype wire

// ----- src/mtnle_req_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mtnle_req_if
// Key event channel: valid/ready handshake with one scan-code event per item.
// ----------------------------------------------------------------------------
interface mtnle_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] make_code;
   logic       key_released;
   logic       last_of_batch;

   modport source (output valid, output make_code, output key_released,
                   output last_of_batch, input ready);
   modport sink   (input valid, input make_code, input key_released,
                   input last_of_batch, output ready);
endinterface
`default_nettype wire

// ----- src/mtnle_rsp_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mtnle_rsp_if
// Result channel: valid/ready handshake with one translated event per item.
// ----------------------------------------------------------------------------
interface mtnle_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_code;
   logic       out_released;
   logic       out_last;
   logic [7:0] pending_letter;

   modport source (output valid, output out_code, output out_released,
                   output out_last, output pending_letter, input ready);
   modport sink   (input valid, input out_code, input out_released,
                   input out_last, input pending_letter, output ready);
endinterface
`default_nettype wire

// ----- src/mtnle_step.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mtnle_step
// Translation of one key event: next entry state, passed code, pending letter.
// ----------------------------------------------------------------------------
module mtnle_step (
   input  wire logic                 enabled,
   input  wire mtnle_pkg::state_type cur,
   input  wire logic [7:0]           code,
   input  wire logic                 rel,
   output mtnle_pkg::state_type      nxt,
   output logic [7:0]                out_code,
   output logic [7:0]                pending
);

   logic       numpad;
   logic [2:0] idx_sum;

   assign numpad = (code >= mtnle_pkg::KEY_FIRST) && (code <= mtnle_pkg::KEY_LAST)
                   && (code != mtnle_pkg::KEY_GAP);
   assign idx_sum = {1'b0, cur.idx} + 3'd1;

   always_comb begin
      nxt      = cur;
      out_code = code;
      if (enabled && numpad) begin
         out_code = '0;
         if (cur.composing && code == cur.group_key && rel) begin
            // short latin groups wrap at three
            if (cur.latin && cur.group_key != mtnle_pkg::KEY_LONG_A
                && cur.group_key != mtnle_pkg::KEY_LONG_B) begin
               nxt.idx = (idx_sum >= 3'd3) ? 2'(idx_sum - 3'd3) : idx_sum[1:0];
            end else begin
               nxt.idx = idx_sum[1:0];
            end
         end else if (cur.composing && code == mtnle_pkg::KEY_EMIT) begin
            out_code = mtnle_pkg::letter_of(cur.group_key, cur.idx, cur.latin);
            if (rel) begin
               nxt.composing = 1'b0;
            end
         end else if (code == mtnle_pkg::KEY_LAYOUT && rel) begin
            nxt.latin = ~cur.latin;
         end else if (rel) begin
            nxt.composing = 1'b1;
            nxt.idx       = '0;
            nxt.group_key = code;
         end
      end
   end

   assign pending = nxt.composing
                    ? mtnle_pkg::letter_of(nxt.group_key, nxt.idx, nxt.latin) : '0;

endmodule
`default_nettype wire

// ----- src/multi_tap_numpad_letter_entry_unit.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// multi_tap_numpad_letter_entry_unit
// Phone-style multi-tap letter entry on the numpad of a scan-code stream.
// ----------------------------------------------------------------------------
// Takes one key event per item and returns one translated event per item.
// Events are captured in an input register, translated combinationally
// against the entry state and land in a result register, so the unit takes
// an item every cycle while the result register can drain, and a result is
// offered once its item has left the input register; the update of the entry
// state (group key, letter index, layout) with each item sets that rate. The
// input side keeps accepting while a result waits, as long as the result
// register can drain. Write csr_wr_en/csr_wr_data only while idle.
`include "assert_macros.svh"

module multi_tap_numpad_letter_entry_unit (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    csr_wr_en,
   input  wire logic    csr_wr_data,
   mtnle_req_if.sink    req_bus,
   mtnle_rsp_if.source  rsp_bus
);

   logic                 enabled_ff;
   logic                 in_valid_ff;
   logic [7:0]           in_code_ff;
   logic                 in_rel_ff;
   logic                 in_last_ff;
   mtnle_pkg::state_type state_ff;
   mtnle_pkg::state_type state_in;
   logic                 out_valid_ff;
   logic [7:0]           out_code_ff;
   logic                 out_rel_ff;
   logic                 out_last_ff;
   logic [7:0]           out_pend_ff;
   logic [7:0]           code_in;
   logic [7:0]           pend_in;
   logic                 advance;
   logic                 take;
   logic                 numpad;
   logic                 plain_evt;
   logic                 muted_evt;

   // an item moves on when the result register is free or draining
   assign advance = in_valid_ff && (!out_valid_ff || rsp_bus.ready);
   assign req_bus.ready = !in_valid_ff || advance;
   assign take = req_bus.valid && req_bus.ready;
   assign numpad = (in_code_ff >= mtnle_pkg::KEY_FIRST)
                   && (in_code_ff <= mtnle_pkg::KEY_LAST)
                   && (in_code_ff != mtnle_pkg::KEY_GAP);
   assign plain_evt = advance && (!enabled_ff || !numpad);
   assign muted_evt = advance && enabled_ff && numpad
                      && (in_code_ff != mtnle_pkg::KEY_EMIT);

   mtnle_step u_step (
      .enabled  (enabled_ff),
      .cur      (state_ff),
      .code     (in_code_ff),
      .rel      (in_rel_ff),
      .nxt      (state_in),
      .out_code (code_in),
      .pending  (pend_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         enabled_ff   <= 1'b0;
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= '0;
      end else begin
         if (csr_wr_en) begin
            enabled_ff <= csr_wr_data;
         end
         if (take) begin
            in_valid_ff <= 1'b1;
         end else if (advance) begin
            in_valid_ff <= 1'b0;
         end
         if (advance) begin
            out_valid_ff <= 1'b1;
            state_ff     <= state_in;
         end else if (rsp_bus.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         in_code_ff <= req_bus.make_code;
         in_rel_ff  <= req_bus.key_released;
         in_last_ff <= req_bus.last_of_batch;
      end
      if (advance) begin
         out_code_ff <= code_in;
         out_rel_ff  <= in_rel_ff;
         out_last_ff <= in_last_ff;
         out_pend_ff <= pend_in;
      end
   end

   assign rsp_bus.valid          = out_valid_ff;
   assign rsp_bus.out_code       = out_code_ff;
   assign rsp_bus.out_released   = out_rel_ff;
   assign rsp_bus.out_last       = out_last_ff;
   assign rsp_bus.pending_letter = out_pend_ff;

   // events outside translation come out untouched
   `CHK_NEXT(a_pass_through, clock, reset, plain_evt, rsp_bus.out_code == $past(in_code_ff))
   // numpad events other than the emit key are suppressed
   `CHK_NEXT(a_suppress, clock, reset, muted_evt, rsp_bus.out_code == 8'd0)
   // entry state only moves with an item
   `CHK_NEXT(a_state_hold, clock, reset, !advance, $stable(state_ff))
   // no pending letter while no group is being composed
   `CHK_NOW(a_idle_pending, clock, reset, advance && !state_in.composing, pend_in == 8'd0)

endmodule
`default_nettype wire

// ----- test/tb_top.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tb_top
// Checks the multi-tap numpad letter entry unit against a cycle-free
// predictor of its entry state: a short directed run, then random word
// sequences and noise under several idling patterns and enable settings.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int PIPE_LATENCY = 4;

   // numpad keys by their printed digit
   localparam logic [7:0] PAD_1 = 8'd79;
   localparam logic [7:0] PAD_2 = 8'd80;
   localparam logic [7:0] PAD_3 = 8'd81;
   localparam logic [7:0] PAD_4 = 8'd75;
   localparam logic [7:0] PAD_5 = 8'd76;
   localparam logic [7:0] PAD_6 = 8'd77;
   localparam logic [7:0] PAD_7 = 8'd71;
   localparam logic [7:0] PAD_8 = 8'd72;
   localparam logic [7:0] PAD_9 = 8'd73;

   // letter keys in table row order
   localparam logic [7:0] GROUP_KEYS [8] = '{PAD_2, PAD_3, PAD_4, PAD_5,
                                             PAD_6, PAD_7, PAD_8, PAD_9};

   typedef struct packed {
      logic [7:0] code;
      logic       released;
      logic       batch_end;
   } key_event_type;

   typedef struct packed {
      logic [7:0] code;
      logic       released;
      logic       batch_end;
      logic [7:0] pending;
   } key_result_type;

   logic clock;
   logic reset;
   logic csr_wr_en;
   logic csr_wr_data;

   mtnle_req_if req_bus ();
   mtnle_rsp_if rsp_bus ();

   multi_tap_numpad_letter_entry_unit dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus)
   );

   key_event_type  pending_events [$];
   key_result_type expected_results [$];

   // predicted entry state
   logic       entry_enabled;
   logic       entry_composing;
   logic       entry_latin;
   logic [1:0] entry_index;
   logic [7:0] entry_group;

   int send_idle_pct;
   int recv_stall_pct;
   int hold_cycles;
   int mismatches;
   int events_loaded;
   bit event_taken;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #2000000;
      $display("FAIL");
      $finish;
   end

   function automatic logic [7:0] letter_for(input logic [7:0] key, input logic [1:0] idx,
                                             input logic latin);
      int grp;
      int group_len;
      grp = -1;
      for (int i = 0; i < 8; i++) begin
         if (GROUP_KEYS[i] == key) grp = i;
      end
      if (grp < 0) return 8'h00;
      if (latin) begin
         group_len = (key == mtnle_pkg::KEY_LONG_A || key == mtnle_pkg::KEY_LONG_B) ? 4 : 3;
         if (int'(idx) >= group_len) return 8'h00;
         return mtnle_pkg::LAT_TAB[grp][idx];
      end
      return mtnle_pkg::CYR_TAB[grp][idx];
   endfunction

   function automatic key_result_type translate_event(input key_event_type ev);
      key_result_type r;
      logic           numpad;
      int             wrap;
      int             next_index;
      r.code      = ev.code;
      r.released  = ev.released;
      r.batch_end = ev.batch_end;
      numpad = ev.code >= mtnle_pkg::KEY_FIRST && ev.code <= mtnle_pkg::KEY_LAST
               && ev.code != mtnle_pkg::KEY_GAP;
      if (entry_enabled && numpad) begin
         r.code = 8'h00;
         if (entry_composing && ev.code == entry_group && ev.released) begin
            wrap = (entry_latin && entry_group != mtnle_pkg::KEY_LONG_A
                    && entry_group != mtnle_pkg::KEY_LONG_B) ? 3 : 4;
            next_index  = (int'(entry_index) + 1) % wrap;
            entry_index = next_index[1:0];
         end else if (entry_composing && ev.code == mtnle_pkg::KEY_EMIT) begin
            r.code = letter_for(entry_group, entry_index, entry_latin);
            if (ev.released) entry_composing = 1'b0;
         end else if (ev.code == mtnle_pkg::KEY_LAYOUT && ev.released) begin
            entry_latin = ~entry_latin;
         end else if (ev.released) begin
            entry_composing = 1'b1;
            entry_index     = 2'd0;
            entry_group     = ev.code;
         end
      end
      r.pending = entry_composing ? letter_for(entry_group, entry_index, entry_latin) : 8'h00;
      return r;
   endfunction

   function automatic void check_field(input string field, input logic [7:0] want,
                                       input logic [7:0] got);
      if (got !== want) begin
         mismatches++;
         $display("%0t: %s mismatch: expected 0x%02h, got 0x%02h", $time, field, want, got);
      end
   endfunction

   // sender: offers the head of the pending queue, holds it until taken
   always @(negedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else if (!req_bus.valid || event_taken) begin
         event_taken = 1'b0;
         if (pending_events.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
            req_bus.valid         <= 1'b1;
            req_bus.make_code     <= pending_events[0].code;
            req_bus.key_released  <= pending_events[0].released;
            req_bus.last_of_batch <= pending_events[0].batch_end;
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // receiver: random stalls plus long hold-offs when asked
   always @(negedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else if (hold_cycles > 0) begin
         hold_cycles--;
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin : watch_channels
      key_event_type  ev;
      key_result_type want;
      if (!reset) begin
         if (req_bus.valid && req_bus.ready) begin
            ev.code      = req_bus.make_code;
            ev.released  = req_bus.key_released;
            ev.batch_end = req_bus.last_of_batch;
            expected_results.push_back(translate_event(ev));
            pending_events.delete(0);
            event_taken = 1'b1;
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_results.size() == 0) begin
               mismatches++;
               $display("%0t: unexpected result: expected none, got code 0x%02h",
                        $time, rsp_bus.out_code);
            end else begin
               want = expected_results.pop_front();
               check_field("out_code", want.code, rsp_bus.out_code);
               check_field("out_released", {7'd0, want.released},
                           {7'd0, rsp_bus.out_released});
               check_field("out_last", {7'd0, want.batch_end}, {7'd0, rsp_bus.out_last});
               check_field("pending_letter", want.pending, rsp_bus.pending_letter);
            end
         end
      end
   end

   task automatic add_event(input logic [7:0] code, input logic released);
      key_event_type ev;
      ev.code      = code;
      ev.released  = released;
      ev.batch_end = ($urandom_range(0, 3) == 0);
      pending_events.push_back(ev);
      events_loaded++;
   endtask

   task automatic add_noise();
      logic [7:0] code;
      if ($urandom_range(0, 1)) begin
         code = 8'($urandom_range(mtnle_pkg::KEY_FIRST, mtnle_pkg::KEY_LAST));
      end else begin
         code = 8'($urandom_range(0, 255));
      end
      add_event(code, 1'($urandom_range(0, 1)));
   endtask

   // a letter group tapped a few times, usually closed by the emit key
   task automatic add_word();
      logic [7:0] key;
      int         taps;
      key  = GROUP_KEYS[3'($urandom_range(0, 7))];
      taps = $urandom_range(1, 5);
      repeat (taps) begin
         if ($urandom_range(0, 2) != 0) add_event(key, 1'b0);
         add_event(key, 1'b1);
         if ($urandom_range(0, 9) == 0) add_noise();
      end
      if ($urandom_range(0, 7) == 0) add_event(mtnle_pkg::KEY_LAYOUT, 1'b1);
      // broken words leave the emit out
      if ($urandom_range(0, 5) != 0) begin
         if ($urandom_range(0, 1)) add_event(mtnle_pkg::KEY_EMIT, 1'b0);
         add_event(mtnle_pkg::KEY_EMIT, 1'b1);
      end
   endtask

   task automatic load_traffic(input int n_events);
      int goal;
      goal = events_loaded + n_events;
      while (events_loaded < goal) begin
         if ($urandom_range(0, 4) == 0) add_noise();
         else add_word();
      end
   endtask

   task automatic wait_drained();
      while (pending_events.size() != 0 || expected_results.size() != 0) @(posedge clock);
   endtask

   task automatic write_enable(input logic value);
      wait_drained();
      repeat (PIPE_LATENCY) @(posedge clock);
      @(negedge clock);
      csr_wr_en     <= 1'b1;
      csr_wr_data   <= value;
      entry_enabled  = value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic run_phase(input logic en, input int send_pct, input int recv_pct,
                            input int n_events, input int hold);
      write_enable(en);
      send_idle_pct  = send_pct;
      recv_stall_pct = recv_pct;
      hold_cycles    = hold;
      load_traffic(n_events);
   endtask

   initial begin
      reset                 = 1'b1;
      csr_wr_en             = 1'b0;
      csr_wr_data           = 1'b0;
      req_bus.valid         = 1'b0;
      req_bus.make_code     = 8'h00;
      req_bus.key_released  = 1'b0;
      req_bus.last_of_batch = 1'b0;
      rsp_bus.ready         = 1'b0;
      entry_enabled         = 1'b0;
      entry_composing       = 1'b0;
      entry_latin           = 1'b0;
      entry_index           = 2'd0;
      entry_group           = 8'h00;
      send_idle_pct         = 0;
      recv_stall_pct        = 0;
      hold_cycles           = 0;
      mismatches            = 0;
      events_loaded         = 0;
      event_taken           = 1'b0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // disabled: everything passes through
      add_event(PAD_2, 1'b1);
      add_event(mtnle_pkg::KEY_EMIT, 1'b0);

      write_enable(1'b1);
      // cyrillic group stepped to its last letter
      add_event(PAD_2, 1'b0);
      repeat (4) add_event(PAD_2, 1'b1);
      // latin layout leaves the index past the end of the group
      add_event(mtnle_pkg::KEY_LAYOUT, 1'b1);
      add_event(mtnle_pkg::KEY_EMIT, 1'b0);
      add_event(mtnle_pkg::KEY_EMIT, 1'b1);
      // emit key released while idle opens a group with no letters
      add_event(mtnle_pkg::KEY_EMIT, 1'b1);
      add_event(mtnle_pkg::KEY_EMIT, 1'b0);
      add_event(mtnle_pkg::KEY_LAYOUT, 1'b1);
      add_event(PAD_1, 1'b1);
      add_event(PAD_9, 1'b1);
      add_event(mtnle_pkg::KEY_LAYOUT, 1'b1);
      add_event(PAD_9, 1'b1);
      // short latin group wraps after three
      repeat (4) add_event(PAD_5, 1'b1);
      add_event(8'h00, 1'b0);
      add_event(8'hFF, 1'b1);
      add_event(mtnle_pkg::KEY_FIRST - 8'd1, 1'b1);
      add_event(mtnle_pkg::KEY_LAST + 8'd1, 1'b0);
      add_event(mtnle_pkg::KEY_GAP, 1'b1);

      run_phase(1'b1, 0, 0, 400, 0);
      run_phase(1'b1, 62, 0, 300, 0);
      run_phase(1'b0, 0, 62, 200, 0);
      run_phase(1'b1, 27, 27, 150, 0);
      // sender stops until everything has come back
      wait_drained();
      load_traffic(150);
      // long receiver hold-off fills the block and stalls its input
      run_phase(1'b1, 0, 0, 300, 300);
      run_phase(1'b1, 27, 27, 200, 0);

      wait_drained();
      repeat (PIPE_LATENCY * 2) @(posedge clock);
      if (mismatches == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
`default_nettype wire
